FILE: rtl/escal_pkg.sv
// Shared constants and helpers for the epoch seconds to calendar converter.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package escal_pkg;

  // Default count of input bits used.
  localparam int SECONDS_BITS_DEF = 32;

  // Width of the shared subtract unit; holds day counts up to 2^34 seconds.
  localparam int UNIT_W = 18;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int BASE_YEAR     = 1970;
  localparam int DAYS_NORMAL   = 365;
  localparam int DAYS_LEAP     = 366;

  // Position of the base year in the 100 and 400 year cycles.
  localparam int BASE_MOD100 = 70;
  localparam int BASE_MOD400 = 370;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  // Length of a month in days for the given leap flag.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/epoch_seconds_to_calendar_unit.sv
// Sequence from accepted start to the done_o strobe: day division, hours, minutes, then
// the walk over whole years and months (Y + M <= 146 at 32 bits, Y years and M months).
// Throughput: one word at a time; busy_o rises after acceptance and falls in the strobe cycle.
// Cost is set by one shared subtract and compare unit: one quotient bit, one year or
// one month per cycle. Reset clears the sequencer and the strobe; no clearing pass.
// Results are shown for exactly one cycle on done_o; the receiver cannot stall.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_unit
  import escal_pkg::*;
#(
  parameter int SECONDS_BITS = SECONDS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        done_o,
  output logic [11:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o
);

  localparam int CNT_W = $clog2(SECONDS_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_HOUR,
    ST_MIN,
    ST_YEAR,
    ST_MONTH
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [SECONDS_BITS-1:0]   sec_q;
  logic [UNIT_W-1:0]         rem_q;
  logic [4:0]                hour_q;
  logic [5:0]                min_q;
  logic [11:0]               year_q;
  logic [6:0]                mod100_q;
  logic [8:0]                mod400_q;
  logic [3:0]                month_q;
  logic                      done_q;
  logic [11:0]               year_out_q;
  logic [3:0]                month_out_q;
  logic [4:0]                day_out_q;
  logic [4:0]                hour_out_q;
  logic [5:0]                minute_out_q;
  logic [5:0]                second_out_q;

  logic                      leap;
  logic [UNIT_W-1:0]         days;
  logic [UNIT_W-1:0]         op_a;
  logic [UNIT_W-1:0]         op_b;
  logic [UNIT_W:0]           diff;
  logic                      ge;

  // Leap year from the year's low bits and the century counters.
  assign leap = ((year_q[1:0] == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);

  // During the year and month walk the low bits of sec_q hold the day count.
  assign days = sec_q[UNIT_W-1:0];

  // Operand selection for the shared subtract and compare unit.
  always_comb begin
    op_a = rem_q;
    op_b = '0;
    case (state_q)
      ST_DAYS: begin
        op_a = {rem_q[UNIT_W-2:0], sec_q[SECONDS_BITS-1]};
        op_b = UNIT_W'(SECS_PER_DAY);
      end
      ST_HOUR: begin
        op_b = UNIT_W'(SECS_PER_HOUR) << cnt_q;
      end
      ST_MIN: begin
        op_b = UNIT_W'(SECS_PER_MIN) << cnt_q;
      end
      ST_YEAR: begin
        op_a = days;
        op_b = leap ? UNIT_W'(DAYS_LEAP) : UNIT_W'(DAYS_NORMAL);
      end
      ST_MONTH: begin
        op_a = days;
        op_b = UNIT_W'(month_len(month_q, leap));
      end
      default: begin
        op_a = rem_q;
        op_b = '0;
      end
    endcase
  end

  // The shared unit: one subtraction whose borrow is the compare result.
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~diff[UNIT_W];

  // Sequencer with its working and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      done_q       <= 1'b0;
      cnt_q        <= '0;
      sec_q        <= '0;
      rem_q        <= '0;
      hour_q       <= '0;
      min_q        <= '0;
      year_q       <= '0;
      mod100_q     <= '0;
      mod400_q     <= '0;
      month_q      <= '0;
      year_out_q   <= '0;
      month_out_q  <= '0;
      day_out_q    <= '0;
      hour_out_q   <= '0;
      minute_out_q <= '0;
      second_out_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            sec_q    <= SECONDS_BITS'(epoch_seconds_i);
            rem_q    <= '0;
            cnt_q    <= CNT_W'(SECONDS_BITS - 1);
            year_q   <= 12'(BASE_YEAR);
            mod100_q <= 7'(BASE_MOD100);
            mod400_q <= 9'(BASE_MOD400);
            month_q  <= MONTH_JAN;
            state_q  <= ST_DAYS;
          end
        end
        // Restoring division by the day length; quotient bits replace sec_q.
        ST_DAYS: begin
          rem_q <= ge ? diff[UNIT_W-1:0] : op_a;
          sec_q <= {sec_q[SECONDS_BITS-2:0], ge};
          if (cnt_q == '0) begin
            cnt_q   <= CNT_W'(4);
            state_q <= ST_HOUR;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        // Hours: five quotient bits against shifted hour lengths.
        ST_HOUR: begin
          if (ge) begin
            rem_q <= diff[UNIT_W-1:0];
          end
          hour_q <= {hour_q[3:0], ge};
          if (cnt_q == '0) begin
            cnt_q   <= CNT_W'(5);
            state_q <= ST_MIN;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        // Minutes: six quotient bits; the remainder is the second.
        ST_MIN: begin
          if (ge) begin
            rem_q <= diff[UNIT_W-1:0];
          end
          min_q <= {min_q[4:0], ge};
          if (cnt_q == '0) begin
            state_q <= ST_YEAR;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        // Walk whole years while the day count covers one.
        ST_YEAR: begin
          if (ge) begin
            sec_q    <= SECONDS_BITS'(diff[UNIT_W-1:0]);
            year_q   <= year_q + 1'b1;
            mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 1'b1;
            mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 1'b1;
          end else begin
            state_q <= ST_MONTH;
          end
        end
        // Walk whole months, then publish the result word.
        ST_MONTH: begin
          if (ge) begin
            sec_q   <= SECONDS_BITS'(diff[UNIT_W-1:0]);
            month_q <= month_q + 1'b1;
          end else begin
            year_out_q   <= year_q;
            month_out_q  <= month_q;
            day_out_q    <= days[4:0] + 5'd1;
            hour_out_q   <= hour_q;
            minute_out_q <= min_q;
            second_out_q <= rem_q[5:0];
            done_q       <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign year_out_o   = year_out_q;
  assign month_out_o  = month_out_q;
  assign day_out_o    = day_out_q;
  assign hour_out_o   = hour_out_q;
  assign minute_out_o = minute_out_q;
  assign second_out_o = second_out_q;

`ifndef SYNTHESIS
  // An accepted word keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not make the block busy");

  // The strobe follows a busy cycle and lasts one cycle.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_o) && !busy_o))
    else $error("result strobe without a preceding conversion");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // Published month lies in calendar range and the published day is at least one.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_out_o >= 4'd1 && month_out_o <= 4'd12 && day_out_o >= 5'd1))
    else $error("month or day out of range");

  // Time of day fields stay below their moduli.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hour_out_o < 5'd24 && minute_out_o < 6'd60 && second_out_o < 6'd60))
    else $error("time of day out of range");
`endif

endmodule
